/* sv/szp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package szp_pkg;

  localparam int MZ_W    = 32;
  localparam int SIG_W   = 32;
  localparam int STEP_W  = 16;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 2;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int SLOTS   = 4;

  localparam logic [IDX_W-1:0] CFG_GAP_LIMIT  = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MIN_SIGNAL = 2'd1;
  localparam logic [IDX_W-1:0] CFG_EDGE_STEP  = 2'd2;
  localparam logic [IDX_W-1:0] CFG_GAP_STEP   = 2'd3;

  localparam logic [MZ_W-1:0]   GAP_LIMIT_RST  = 32'd229376;
  localparam logic [SIG_W-1:0]  MIN_SIGNAL_RST = 32'd100;
  localparam logic [STEP_W-1:0] EDGE_STEP_RST  = 16'd6554;
  localparam logic [STEP_W-1:0] GAP_STEP_RST   = 16'd655;

  // result slots of one item, in emission order
  localparam logic [SLOTS-1:0] SEL_AUX1  = 4'b0001;
  localparam logic [SLOTS-1:0] SEL_AUX2  = 4'b0010;
  localparam logic [SLOTS-1:0] SEL_POINT = 4'b0100;
  localparam logic [SLOTS-1:0] SEL_TRAIL = 4'b1000;

  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_LATER  = 2'd2;

  typedef struct packed {
    logic [MZ_W-1:0]   gap_limit;
    logic [SIG_W-1:0]  min_signal;
    logic [STEP_W-1:0] edge_step;
    logic [STEP_W-1:0] gap_step;
  } szp_cfg_t;

  typedef struct packed {
    logic [SLOTS-1:0] mask;
    logic [MZ_W-1:0]  aux1_mz;
    logic [MZ_W-1:0]  aux2_mz;
    logic [SIG_W-1:0] aux_sig;
    logic [MZ_W-1:0]  mz;
    logic [SIG_W-1:0] sig;
    logic [MZ_W-1:0]  trail_mz;
  } szp_cmd_t;

endpackage

`default_nettype wire

/* sv/szp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module szp_front
  import szp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire szp_cfg_t         cfg,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [MZ_W-1:0]  in_mz,
  input  wire logic [SIG_W-1:0] in_sig,
  input  wire logic             in_last,
  output logic                  push,
  output szp_cmd_t              push_cmd,
  input  wire logic             q_full
);

  logic [MZ_W-1:0]  prev_mz_r;
  logic [SIG_W-1:0] prev_sig_r;
  logic [1:0]       pos_r;
  logic [1:0]       pos_nxt;

  logic             s1_valid_r;
  logic [MZ_W-1:0]  s1_mz_r;
  logic [SIG_W-1:0] s1_sig_r;
  logic [MZ_W-1:0]  s1_prev_mz_r;
  logic [SIG_W-1:0] s1_prev_sig_r;
  logic [1:0]       s1_pos_r;
  logic             s1_last_r;
  logic             s1_strong_r;
  logic             s1_eq_r;
  logic [MZ_W:0]    s1_delta_r;

  logic             s2_valid_r;
  logic [MZ_W-1:0]  s2_mz_r;
  logic [SIG_W-1:0] s2_sig_r;
  logic [MZ_W-1:0]  s2_prev_mz_r;
  logic [1:0]       s2_pos_r;
  logic             s2_last_r;
  logic             s2_strong_r;
  logic             s2_eq_r;
  logic             s2_gap_r;
  logic [MZ_W+2:0]  s2_d3_r;
  logic [SIG_W-1:0] s2_low_r;
  logic [MZ_W-1:0]  s2_q_r;
  logic [MZ_W-1:0]  s2_g1_r;
  logic [MZ_W-1:0]  s2_g2_r;
  logic [MZ_W-1:0]  s2_t_r;

  logic             accept;
  logic             s2_take;
  logic [MZ_W:0]    delta;

  logic [MZ_W+2:0]  d3;
  logic [MZ_W:0]    q_raw;
  logic [MZ_W:0]    g1_raw;
  logic [MZ_W:0]    g2_raw;
  logic [MZ_W:0]    t_raw;
  logic             gap;

  logic [MZ_W+2:0]  edge_ext;
  logic [MZ_W+2:0]  inc;
  logic [MZ_W+3:0]  p_sum;
  logic [MZ_W-1:0]  pred;
  logic             later;
  logic             dropped;
  logic             pred_ok;
  logic             q_ok;

  assign push     = s2_valid_r && !q_full;
  assign s2_take  = !s2_valid_r || push;
  assign in_ready = !s1_valid_r || s2_take;
  assign accept   = in_valid && in_ready;
  assign delta    = {1'b0, in_mz} - {1'b0, prev_mz_r};

  always_comb begin
    if (in_last) begin
      pos_nxt = POS_FIRST;
    end else if (pos_r == POS_FIRST) begin
      pos_nxt = POS_SECOND;
    end else begin
      pos_nxt = POS_LATER;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_mz_r  <= '0;
      prev_sig_r <= '0;
      pos_r      <= POS_FIRST;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        prev_mz_r  <= in_mz;
        prev_sig_r <= in_sig;
        pos_r      <= pos_nxt;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mz_r       <= in_mz;
      s1_sig_r      <= in_sig;
      s1_prev_mz_r  <= prev_mz_r;
      s1_prev_sig_r <= prev_sig_r;
      s1_pos_r      <= pos_r;
      s1_last_r     <= in_last;
      s1_strong_r   <= in_sig > cfg.min_signal;
      s1_eq_r       <= in_mz == prev_mz_r;
      s1_delta_r    <= delta;
    end
  end

  // stage 2: gap test, triple delta, saturated offsets
  always_comb begin
    d3     = {{2{s1_delta_r[MZ_W]}}, s1_delta_r}
           + {s1_delta_r[MZ_W], s1_delta_r, 1'b0};
    gap    = $signed(s1_delta_r) > $signed({1'b0, cfg.gap_limit});
    q_raw  = {1'b0, s1_mz_r} - {{(MZ_W-STEP_W+1){1'b0}}, cfg.edge_step};
    g1_raw = {1'b0, s1_prev_mz_r} + {{(MZ_W-STEP_W+1){1'b0}}, cfg.gap_step};
    g2_raw = {1'b0, s1_mz_r} - {{(MZ_W-STEP_W+1){1'b0}}, cfg.gap_step};
    t_raw  = {1'b0, s1_mz_r} + {{(MZ_W-STEP_W+1){1'b0}}, cfg.edge_step};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_take) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid_r) begin
      s2_mz_r      <= s1_mz_r;
      s2_sig_r     <= s1_sig_r;
      s2_prev_mz_r <= s1_prev_mz_r;
      s2_pos_r     <= s1_pos_r;
      s2_last_r    <= s1_last_r;
      s2_strong_r  <= s1_strong_r;
      s2_eq_r      <= s1_eq_r;
      s2_gap_r     <= gap;
      s2_d3_r      <= d3;
      s2_low_r     <= (s1_sig_r < s1_prev_sig_r) ? s1_sig_r : s1_prev_sig_r;
      s2_q_r       <= q_raw[MZ_W] ? '0 : q_raw[MZ_W-1:0];
      s2_g1_r      <= g1_raw[MZ_W] ? '1 : g1_raw[MZ_W-1:0];
      s2_g2_r      <= g2_raw[MZ_W] ? '0 : g2_raw[MZ_W-1:0];
      s2_t_r       <= t_raw[MZ_W] ? '1 : t_raw[MZ_W-1:0];
    end
  end

  // stage 3: predicted zero point and result plan
  always_comb begin
    edge_ext = {{(MZ_W-STEP_W+3){1'b0}}, cfg.edge_step};
    inc      = ($signed(s2_d3_r) < $signed(edge_ext)) ? s2_d3_r : edge_ext;
    p_sum    = {4'b0, s2_prev_mz_r} + {inc[MZ_W+2], inc};
    if (p_sum[MZ_W+3]) begin
      pred = '0;
    end else if (|p_sum[MZ_W+2:MZ_W]) begin
      pred = '1;
    end else begin
      pred = p_sum[MZ_W-1:0];
    end
    later   = s2_pos_r[1];
    dropped = later && s2_eq_r;
    pred_ok = later && !s2_eq_r && s2_strong_r && (pred < s2_mz_r);
    q_ok    = !dropped && !s2_last_r && s2_strong_r
           && (!pred_ok || (s2_q_r > pred)) && (s2_q_r > s2_prev_mz_r);

    push_cmd.mz       = s2_mz_r;
    push_cmd.sig      = s2_sig_r;
    push_cmd.trail_mz = s2_t_r;
    push_cmd.mask     = (dropped ? '0 : SEL_POINT) | (s2_last_r ? SEL_TRAIL : '0);
    if (s2_pos_r == POS_FIRST) begin
      push_cmd.aux1_mz = s2_q_r;
      push_cmd.aux2_mz = s2_q_r;
      push_cmd.aux_sig = '0;
      push_cmd.mask    = push_cmd.mask | SEL_AUX1;
    end else if (later && s2_gap_r) begin
      push_cmd.aux1_mz = s2_g1_r;
      push_cmd.aux2_mz = s2_g2_r;
      push_cmd.aux_sig = s2_low_r;
      push_cmd.mask    = push_cmd.mask | SEL_AUX1 | SEL_AUX2;
    end else begin
      push_cmd.aux1_mz = pred;
      push_cmd.aux2_mz = s2_q_r;
      push_cmd.aux_sig = '0;
      push_cmd.mask    = push_cmd.mask | (pred_ok ? SEL_AUX1 : '0)
                       | (q_ok ? SEL_AUX2 : '0);
    end
  end

endmodule

`default_nettype wire

/* sv/szp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none

module szp_queue
  import szp_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire szp_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output szp_cmd_t      head,
  output logic          empty
);

  szp_cmd_t            entry_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign full  = count_r == QCNT_W'(QDEPTH);
  assign empty = count_r == '0;
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !(pop && !empty)) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && pop && !empty) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

/* sv/szp_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module szp_back
  import szp_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire szp_cmd_t         head,
  input  wire logic             empty,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [MZ_W-1:0]       out_mz,
  output logic [SIG_W-1:0]      out_sig,
  output logic                  out_last
);

  logic [SLOTS-1:0] done_r;
  logic [SLOTS-1:0] done_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic [MZ_W-1:0]  out_mz_r;
  logic [SIG_W-1:0] out_sig_r;
  logic             out_last_r;

  logic [SLOTS-1:0] live;
  logic [SLOTS-1:0] sel;
  logic [SLOTS-1:0] rest;
  logic             slot_free;
  logic             step;
  logic             emit;
  logic [MZ_W-1:0]  sel_mz;
  logic [SIG_W-1:0] sel_sig;

  assign live      = head.mask & ~done_r;
  assign sel       = live & (~live + 1'b1);
  assign rest      = live & ~sel;
  assign slot_free = !out_valid_r || out_ready;
  assign step      = !empty && ((live == '0) || slot_free);
  assign emit      = step && (live != '0);
  assign pop       = step && (rest == '0);

  always_comb begin
    case (sel)
      SEL_AUX1: begin
        sel_mz  = head.aux1_mz;
        sel_sig = head.aux_sig;
      end
      SEL_AUX2: begin
        sel_mz  = head.aux2_mz;
        sel_sig = head.aux_sig;
      end
      SEL_POINT: begin
        sel_mz  = head.mz;
        sel_sig = head.sig;
      end
      SEL_TRAIL: begin
        sel_mz  = head.trail_mz;
        sel_sig = '0;
      end
      default: begin
        sel_mz  = '0;
        sel_sig = '0;
      end
    endcase
  end

  always_comb begin
    if (pop) begin
      done_nxt = '0;
    end else if (emit) begin
      done_nxt = done_r | sel;
    end else begin
      done_nxt = done_r;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_mz_r   <= sel_mz;
      out_sig_r  <= sel_sig;
      out_last_r <= rest == '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_mz    = out_mz_r;
  assign out_sig   = out_sig_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

/* sv/spectrum_zero_padding_stream.sv */
// Zero padding of one mass-spectrum scan.
// in_ carries one point per beat: m/z (unsigned Q16.16) and intensity in tdata,
// in_tlast marks the final point of the scan. out_ carries the padded point
// list, one point per beat; out_tlast marks the last point caused by an input.
// cfg_ writes gap_limit (0), min_signal (1), edge_step (2), gap_step (3);
// write only while no point is in flight.
// The first result of a point passes the front stage registers, the plan queue
// and the output register. A three-stage front computes all results of a
// point and queues them as one plan (four entries deep); the back emits one
// result per cycle from the queue head while the output register is free. A
// point has one to four results, a dropped point none unless it ends the scan;
// the input accepts one beat per cycle while the queue has room.
// Reset clears the previous point, the scan position, the queue and the output
// register, and loads the register defaults.
// When out_tready is low the output register holds its beat, the back stops,
// the queue fills and in_tready falls once the front stages are full.
`timescale 1ns / 1ps
`default_nettype none

module spectrum_zero_padding_stream
  import szp_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [MZ_W+SIG_W-1:0]  in_tdata,   // mz_value, intensity
  input  wire logic                   in_tlast,   // scan_end
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [MZ_W+SIG_W-1:0]       out_tdata,  // out_mz, out_intensity
  output logic                        out_tlast,  // run_last
  input  wire logic                   cfg_we,
  input  wire logic [IDX_W-1:0]       cfg_addr,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  szp_cfg_t   cfg_r;
  szp_cmd_t   push_cmd;
  szp_cmd_t   head;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  logic [MZ_W-1:0]  out_mz;
  logic [SIG_W-1:0] out_sig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gap_limit  <= GAP_LIMIT_RST;
      cfg_r.min_signal <= MIN_SIGNAL_RST;
      cfg_r.edge_step  <= EDGE_STEP_RST;
      cfg_r.gap_step   <= GAP_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_GAP_LIMIT:  cfg_r.gap_limit  <= cfg_wdata[MZ_W-1:0];
        CFG_MIN_SIGNAL: cfg_r.min_signal <= cfg_wdata[SIG_W-1:0];
        CFG_EDGE_STEP:  cfg_r.edge_step  <= cfg_wdata[STEP_W-1:0];
        CFG_GAP_STEP:   cfg_r.gap_step   <= cfg_wdata[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  szp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_mz    (in_tdata[MZ_W-1:0]),
    .in_sig   (in_tdata[MZ_W+SIG_W-1:MZ_W]),
    .in_last  (in_tlast),
    .push     (q_push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  szp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty)
  );

  szp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_mz    (out_mz),
    .out_sig   (out_sig),
    .out_last  (out_tlast)
  );

  assign out_tdata = {out_sig, out_mz};

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("plan queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("plan queue popped while empty");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat valid right after reset");

  a_result_needs_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_tvalid || out_tready) && q_empty |=> !out_tvalid)
    else $error("result beat without a queued plan");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import szp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 16;

  typedef struct {
    logic [MZ_W-1:0]  mz;
    logic [SIG_W-1:0] sig;
    logic             last;
  } padded_pt_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [MZ_W+SIG_W-1:0]   in_tdata = '0;
  logic                    in_tlast = 1'b0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [MZ_W+SIG_W-1:0]   out_tdata;
  logic                    out_tlast;
  logic                    cfg_we = 1'b0;
  logic [IDX_W-1:0]        cfg_addr = '0;
  logic [CFG_W-1:0]        cfg_wdata = '0;

  logic [MZ_W-1:0]   thr_gap = GAP_LIMIT_RST;
  logic [SIG_W-1:0]  thr_signal = MIN_SIGNAL_RST;
  logic [STEP_W-1:0] step_edge = EDGE_STEP_RST;
  logic [STEP_W-1:0] step_gap = GAP_STEP_RST;

  logic [MZ_W-1:0]   last_mz = '0;
  logic [SIG_W-1:0]  last_sig = '0;
  logic [1:0]        scan_pos = POS_FIRST;

  padded_pt_t padded_q[$];
  padded_pt_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int points_sent = 0;
  int scans_closed = 0;
  int points_checked = 0;
  int cycle_count = 0;

  spectrum_zero_padding_stream DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // mz_value, intensity
    .in_tlast   (in_tlast),   // scan_end
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // out_mz, out_intensity
    .out_tlast  (out_tlast),  // run_last
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [MZ_W-1:0] clamp_mz(input longint v);
    if (v < 0) return '0;
    if (v > longint'(64'hFFFF_FFFF)) return '1;
    return v[MZ_W-1:0];
  endfunction

  function automatic void add_expected(input logic [MZ_W-1:0] mz, input logic [SIG_W-1:0] sig);
    padded_pt_t pt;
    pt.mz = mz;
    pt.sig = sig;
    pt.last = 1'b0;
    padded_q.insert(padded_q.size(), pt);
  endfunction

  function automatic void pad_point(input logic [MZ_W-1:0] mz, input logic [SIG_W-1:0] sig,
                                    input logic fin);
    longint delta, d3, inc;
    logic loud, keep, have_pred;
    logic [MZ_W-1:0] pred, p, q;
    logic [SIG_W-1:0] low;
    int n;
    delta = longint'({32'd0, mz}) - longint'({32'd0, last_mz});
    loud = sig > thr_signal;
    keep = 1'b1;
    have_pred = 1'b0;
    pred = '0;
    n = 0;
    if (scan_pos == POS_FIRST) begin
      add_expected(clamp_mz(longint'({32'd0, mz}) - longint'(step_edge)), '0);
      n++;
    end else if (scan_pos != POS_SECOND && delta > longint'({32'd0, thr_gap})) begin
      low = (sig < last_sig) ? sig : last_sig;
      add_expected(clamp_mz(longint'({32'd0, last_mz}) + longint'(step_gap)), low);
      add_expected(clamp_mz(longint'({32'd0, mz}) - longint'(step_gap)), low);
      n += 2;
    end else begin
      if (scan_pos != POS_SECOND) begin
        if (delta == 0) begin
          keep = 1'b0;
        end else begin
          d3 = delta * 3;
          inc = (d3 < longint'(step_edge)) ? d3 : longint'(step_edge);
          p = clamp_mz(longint'({32'd0, last_mz}) + inc);
          if (loud && p < mz) begin
            add_expected(p, '0);
            n++;
            pred = p;
            have_pred = 1'b1;
          end
        end
      end
      if (keep && !fin) begin
        q = clamp_mz(longint'({32'd0, mz}) - longint'(step_edge));
        if (loud && (!have_pred || q > pred) && q > last_mz) begin
          add_expected(q, '0);
          n++;
        end
      end
    end
    if (keep) begin
      add_expected(mz, sig);
      n++;
    end
    if (fin) begin
      add_expected(clamp_mz(longint'({32'd0, mz}) + longint'(step_edge)), '0);
      n++;
    end
    if (n > 0)
      padded_q[padded_q.size()-1].last = 1'b1;
    last_mz = mz;
    last_sig = sig;
    if (fin)
      scan_pos = POS_FIRST;
    else if (scan_pos == POS_FIRST)
      scan_pos = POS_SECOND;
    else
      scan_pos = POS_LATER;
  endfunction

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("simulation failed");
      $finish;
    end else if (rst_n) begin
      if (in_tvalid && in_tready) begin
        pad_point(in_tdata[MZ_W-1:0], in_tdata[MZ_W+SIG_W-1:MZ_W], in_tlast);
        points_sent++;
        if (in_tlast)
          scans_closed++;
      end
      if (out_tvalid && out_tready) begin
        if (padded_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual mz=%h sig=%h last=%b",
                   $time, out_tdata[MZ_W-1:0], out_tdata[MZ_W+SIG_W-1:MZ_W], out_tlast);
        end else begin
          want = padded_q.pop_front();
          points_checked++;
          if (out_tdata[MZ_W-1:0] !== want.mz) begin
            errors++;
            $display("%0t: out_mz expected %h actual %h", $time, want.mz,
                     out_tdata[MZ_W-1:0]);
          end
          if (out_tdata[MZ_W+SIG_W-1:MZ_W] !== want.sig) begin
            errors++;
            $display("%0t: out_intensity expected %h actual %h", $time, want.sig,
                     out_tdata[MZ_W+SIG_W-1:MZ_W]);
          end
          if (out_tlast !== want.last) begin
            errors++;
            $display("%0t: run_last expected %b actual %b", $time, want.last, out_tlast);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n)
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_point(input logic [MZ_W-1:0] mz, input logic [SIG_W-1:0] sig,
                            input logic fin);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {sig, mz};
    in_tlast = fin;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (padded_q.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_GAP_LIMIT:  thr_gap = val;
      CFG_MIN_SIGNAL: thr_signal = val;
      CFG_EDGE_STEP:  step_edge = val[STEP_W-1:0];
      CFG_GAP_STEP:   step_gap = val[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [CFG_W-1:0] gap_thr, input logic [CFG_W-1:0] min_sig,
                           input logic [CFG_W-1:0] edge_w, input logic [CFG_W-1:0] gap_w);
    drain();
    write_reg(CFG_GAP_LIMIT, gap_thr);
    write_reg(CFG_MIN_SIGNAL, min_sig);
    write_reg(CFG_EDGE_STEP, edge_w);
    write_reg(CFG_GAP_STEP, gap_w);
  endtask

  task automatic test_edge_points;
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_point(32'h0000_1000, 32'h0000_0065, 1'b1);
  endtask

  task automatic test_scan_cases;
    send_point(32'h0064_0000, 32'd500, 1'b0);
    send_point(32'h0064_8000, 32'd1000, 1'b0);
    send_point(32'h0064_851E, 32'd800, 1'b0);
    send_point(32'h0064_851E, 32'd900, 1'b0);
    send_point(32'h006E_0000, 32'd50, 1'b0);
    send_point(32'h006E_0CCD, 32'd200, 1'b0);
    send_point(32'h006D_0000, 32'd300, 1'b0);
    send_point(32'h006D_0000, 32'd100, 1'b1);
  endtask

  task automatic test_reg_extremes;
    load_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0000_0100, 32'd5, 1'b0);
    send_point(32'h0000_0200, 32'd0, 1'b0);
    send_point(32'h0001_0000, 32'hFFFF_FFFF, 1'b0);
    send_point(32'hFFFF_FF00, 32'd1, 1'b1);
    load_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_point(32'h8000_0000, 32'hFFFF_FFFE, 1'b0);
    send_point(32'h8000_0000, 32'd7, 1'b1);
  endtask

  task automatic random_scans(input int target);
    int sent, len;
    logic [MZ_W-1:0] mz, step;
    logic [SIG_W-1:0] sig;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(99) < 85) begin
        len = $urandom_range(1, 10);
        mz = ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h0064_0000, 32'h07D0_0000);
        for (int i = 0; i < len; i++) begin
          if (i > 0) begin
            case ($urandom_range(9))
              0:       step = '0;
              1, 2, 3, 4: step = $urandom_range(1, 3 * step_edge + 3);
              5, 6:    step = thr_gap + $urandom_range(2) - 1;
              7:       step = $urandom_range(1, 32'h0010_0000);
              8:       step = 32'd0 - $urandom_range(1, 4 * step_edge + 1);
              default: step = $urandom;
            endcase
            mz = mz + step;
          end
          case ($urandom_range(7))
            0:       sig = '0;
            1:       sig = '1;
            2, 3:    sig = thr_signal + $urandom_range(2) - 1;
            4, 5:    sig = $urandom_range(0, 1000);
            default: sig = $urandom;
          endcase
          send_point(mz, sig, i == len - 1);
        end
        sent += len;
      end else begin
        len = $urandom_range(1, 4);
        repeat (len) send_point($urandom, $urandom, $urandom_range(1));
        sent += len;
      end
    end
  endtask

  task automatic test_random_phase(input int idle_in, input int stall_out,
                                   input logic [CFG_W-1:0] gap_thr,
                                   input logic [CFG_W-1:0] min_sig,
                                   input logic [CFG_W-1:0] edge_w,
                                   input logic [CFG_W-1:0] gap_w);
    load_regs(gap_thr, min_sig, edge_w, gap_w);
    send_idle_pct = idle_in;
    recv_stall_pct = stall_out;
    random_scans(110);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_edge_points();
    test_scan_cases();
    test_reg_extremes();

    test_random_phase(0, 0, GAP_LIMIT_RST, MIN_SIGNAL_RST, EDGE_STEP_RST, GAP_STEP_RST);
    test_random_phase(53, 0, $urandom_range(1, 32'h0008_0000), $urandom_range(0, 1000),
                      {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 20000))},
                      {16'($urandom_range(0, 65535)), 16'($urandom_range(1, 2000))});
    test_random_phase(0, 53, $urandom_range(32'h0001_0000, 32'h0010_0000), $urandom,
                      $urandom, $urandom);
    test_random_phase(32, 32, 32'h0000_0000, 32'h0000_0000, 32'h0000_FFFF, 32'h0000_0000);

    drain();
    if (padded_q.size() != 0) begin
      errors += padded_q.size();
      $display("%0t: %0d expected beats never arrived", $time, padded_q.size());
    end
    $display("%0d points in %0d closed scans sent, %0d padded points checked", points_sent,
             scans_closed, points_checked);
    $display("register extremes and four idle/stall mixes exercised, %0d errors", errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/szp_pkg.sv
sv/szp_front.sv
sv/szp_queue.sv
sv/szp_back.sv
sv/spectrum_zero_padding_stream.sv
tb/tb.sv
